// ===== src/sst_pkg.sv =====
// Shared constants for the segment tree range-sum block.
// No dependencies.
package sst_pkg;

  localparam int LEAVES_DEFAULT = 1024;
  localparam int IDX_W          = 10;
  localparam int DATA_W         = 32;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

endpackage

// ===== src/segment_tree_range_sum.sv =====
// Segment tree range-sum block: point update, inclusive range sum query.
// Depends on sst_pkg and sst_mem.
//
//   channel   ports                                           handshake
//   request   cmd, first_index, last_index, new_value         start & !busy
//   result    range_sum                                       done, one cycle
//
// Node sums sit in one memory indexed by heap position (root at 1).
// After reset, a clearing pass zeroes the whole memory; busy is high
// throughout. An update writes one node per tree level, with the sibling read
// alongside, and keeps busy high. A query keeps busy high while it alternates
// S_Q_TOP and S_Q_R at each level for the left and right boundary reads on the
// single read port; done follows in the first idle cycle. The result strobe
// cannot be stalled.
module segment_tree_range_sum #(
  parameter int LEAVES = sst_pkg::LEAVES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cmd,
  input  logic [sst_pkg::IDX_W-1:0]        first_index,
  input  logic [sst_pkg::IDX_W-1:0]        last_index,
  input  logic signed [sst_pkg::DATA_W-1:0] new_value,
  output logic                             done,
  output logic signed [sst_pkg::DATA_W-1:0] range_sum
);

  localparam int LVL = $clog2(LEAVES);
  localparam int NW  = LVL + 1;
  localparam int QW  = NW + 1;
  localparam int DW  = sst_pkg::DATA_W;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_U_LEAF = 3'd2;
  localparam logic [2:0] S_U_ADD  = 3'd3;
  localparam logic [2:0] S_Q_TOP  = 3'd4;
  localparam logic [2:0] S_Q_R    = 3'd5;

  logic [2:0]    state, state_next;
  logic [NW-1:0] clr_addr;
  logic [NW-1:0] node;
  logic [DW-1:0] val;
  logic [QW-1:0] l, r;
  logic [DW-1:0] acc;
  logic          pend;

  logic          wr_en, rd_en;
  logic [NW-1:0] wr_addr, rd_addr;
  logic [DW-1:0] wr_data, rd_data;

  logic [31:0]   first32, last32, leaves32, hi32;
  logic [NW-1:0] parent;
  logic [DW-1:0] acc_in, upd_sum;

  sst_mem #(.ADDR_W(NW), .DATA_W(DW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy     = (state != S_IDLE);
  assign first32  = 32'(first_index);
  assign last32   = 32'(last_index);
  assign leaves32 = 32'(LEAVES);
  assign hi32     = (last32 >= leaves32) ? leaves32 - 32'd1 : last32;
  assign parent   = node >> 1;
  assign upd_sum  = val + rd_data;
  assign acc_in   = pend ? acc + rd_data : acc;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = node ^ NW'(1);
    unique case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_U_LEAF: begin
        wr_en   = 1'b1;
        wr_addr = node;
        wr_data = val;
        rd_en   = 1'b1;
      end
      S_U_ADD: begin
        wr_en   = 1'b1;
        wr_addr = parent;
        wr_data = upd_sum;
        rd_en   = (parent != NW'(1));
        rd_addr = parent ^ NW'(1);
      end
      S_Q_TOP: begin
        rd_en   = (l < r) && l[0];
        rd_addr = l[NW-1:0];
      end
      S_Q_R: begin
        rd_en   = r[0];
        rd_addr = r[NW-1:0] - NW'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_addr == '1) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          if (cmd == sst_pkg::CMD_QUERY) begin
            state_next = S_Q_TOP;
          end else if (first32 < leaves32) begin
            state_next = S_U_LEAF;
          end
        end
      end
      S_U_LEAF: state_next = S_U_ADD;
      S_U_ADD:  if (parent == NW'(1)) state_next = S_IDLE;
      S_Q_TOP:  state_next = (l < r) ? S_Q_R : S_IDLE;
      S_Q_R:    state_next = S_Q_TOP;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
      pend     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + NW'(1);
      end
      unique case (state)
        S_IDLE: begin
          pend <= 1'b0;
          acc  <= '0;
          if (start) begin
            node <= NW'(leaves32 + first32);
            val  <= new_value;
            if (first32 > hi32) begin
              l <= '0;
              r <= '0;
            end else begin
              l <= QW'(leaves32 + first32);
              r <= QW'(leaves32 + hi32 + 32'd1);
            end
          end
        end
        S_U_ADD: begin
          val  <= upd_sum;
          node <= parent;
        end
        S_Q_TOP: begin
          acc <= acc_in;
          if (l < r) begin
            pend <= l[0];
            l    <= l + QW'(l[0]);
          end else begin
            done      <= 1'b1;
            range_sum <= $signed(acc_in);
          end
        end
        S_Q_R: begin
          acc  <= acc_in;
          pend <= r[0];
          l    <= l >> 1;
          r    <= r >> 1;
        end
        default: begin
        end
      endcase
    end
  end

  a_done_after_query: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_Q_TOP))
    else $error("result strobe without a finished query");

  a_clear_complete: assert property (@(posedge clk) disable iff (rst)
    ($past(state == S_CLEAR) && state == S_IDLE) |-> $past(clr_addr) == '1)
    else $error("clearing pass ended early");

  a_update_node: assert property (@(posedge clk) disable iff (rst)
    (state == S_U_ADD) |-> node > NW'(1))
    else $error("update walked past the root");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> wr_addr != rd_addr)
    else $error("read and write of the same node in one cycle");

endmodule

// ===== src/sst_mem.sv =====
// Node-sum memory: one write port, one read port, registered read data.
// Depends on sst_pkg.
module sst_mem #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = sst_pkg::DATA_W
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
